// File: hdl/sfctd_pkg.sv
// ----------------------------------------------------------------------------
// Sync frame checksum tilt decode package
// Shared constants, the arctangent table and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfctd_pkg;

  localparam int DEFAULT_CORDIC_STEPS = 16;
  localparam int STEP_W               = 5;    // indexes the 22-entry table
  localparam int CFG_DATA_W           = 16;
  localparam int CFG_INDEX_W          = 1;
  localparam int PAYLOAD_LEN          = 10;
  localparam int XY_W                 = 28;   // 17-bit difference, 8 fraction bits, gain
  localparam int Z_W                  = 25;   // angle in 1/256 centidegree
  localparam int ANGLE_LIMIT          = 18000;
  localparam int QUARTER_TURN         = 9000 * 256;

  localparam logic [7:0]  SYNC_RESET   = 8'hAA;
  localparam logic [15:0] CENTER_RESET = 16'd511;
  localparam logic [3:0]  FRAME_LAST   = 4'd11;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_CENTER = 1'b1;

  typedef struct packed {
    logic frame_start;
    logic data_take;
    logic cordic_init;
    logic pitch_sel;
    logic cordic_step;
    logic roll_capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic pos_last;
    logic sum_match;
    logic cordic_last;
    logic out_busy;
  } dp_status_t;

  // Rounded atan(2^-i) in units of 1/256 centidegree.
  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(1152000);
      5'd1:    v = Z_W'(680065);
      5'd2:    v = Z_W'(359328);
      5'd3:    v = Z_W'(182400);
      5'd4:    v = Z_W'(91554);
      5'd5:    v = Z_W'(45822);
      5'd6:    v = Z_W'(22916);
      5'd7:    v = Z_W'(11459);
      5'd8:    v = Z_W'(5730);
      5'd9:    v = Z_W'(2865);
      5'd10:   v = Z_W'(1432);
      5'd11:   v = Z_W'(716);
      5'd12:   v = Z_W'(358);
      5'd13:   v = Z_W'(179);
      5'd14:   v = Z_W'(90);
      5'd15:   v = Z_W'(45);
      5'd16:   v = Z_W'(22);
      5'd17:   v = Z_W'(11);
      5'd18:   v = Z_W'(6);
      5'd19:   v = Z_W'(3);
      5'd20:   v = Z_W'(1);
      5'd21:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/sfctd_ctrl.sv
// ----------------------------------------------------------------------------
// Sync frame checksum tilt decode controller
// Frame hunting, byte sequencing and the order of the two CORDIC runs.
// ----------------------------------------------------------------------------
module sfctd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sfctd_pkg::dp_status_t status,
  output sfctd_pkg::dp_cmd_t    cmd
);
  import sfctd_pkg::*;

  typedef enum logic [5:0] {
    S_HUNT       = 6'b000001,
    S_DATA       = 6'b000010,
    S_ROLL       = 6'b000100,
    S_PITCH_INIT = 6'b001000,
    S_PITCH      = 6'b010000,
    S_DONE       = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !(state == S_HUNT || state == S_DATA);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HUNT: begin
        if (accept && status.sync_hit) begin
          cmd.frame_start = 1'b1;
          state_next      = S_DATA;
        end
      end
      S_DATA: begin
        if (accept) begin
          if (status.pos_last) begin
            if (status.sum_match) begin
              cmd.cordic_init = 1'b1;
              state_next      = S_ROLL;
            end else begin
              state_next = S_HUNT;
            end
          end else begin
            cmd.data_take = 1'b1;
          end
        end
      end
      S_ROLL: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) begin
          state_next = S_PITCH_INIT;
        end
      end
      S_PITCH_INIT: begin
        cmd.roll_capture = 1'b1;
        cmd.cordic_init  = 1'b1;
        cmd.pitch_sel    = 1'b1;
        state_next       = S_PITCH;
      end
      S_PITCH: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_HUNT;
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/sfctd_datapath.sv
// ----------------------------------------------------------------------------
// Sync frame checksum tilt decode datapath
// Configuration registers, payload capture, checksum, one shared vectoring
// CORDIC iteration per cycle and the output register.
// ----------------------------------------------------------------------------
module sfctd_datapath #(
  parameter int CORDIC_STEPS = sfctd_pkg::DEFAULT_CORDIC_STEPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sfctd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfctd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                         rx_byte,
  input  sfctd_pkg::dp_cmd_t                 cmd,
  output sfctd_pkg::dp_status_t              status,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [7:0]                         stick_x,
  output logic [7:0]                         stick_y,
  output logic [7:0]                         button_first,
  output logic [7:0]                         button_second,
  output logic [15:0]                        accel_x,
  output logic [15:0]                        accel_y,
  output logic [15:0]                        accel_z,
  output logic signed [15:0]                 roll_centideg,
  output logic signed [15:0]                 pitch_centideg
);
  import sfctd_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [Z_W-9:0] LIM_HI = (Z_W-8)'(ANGLE_LIMIT);
  localparam logic signed [Z_W-9:0] LIM_LO = -LIM_HI;

  logic [7:0]  sync_byte;
  logic [15:0] accel_center;
  logic [3:0]  byte_position;
  logic [7:0]  running_sum;
  logic [7:0]  payload_store [PAYLOAD_LEN];

  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [15:0]        az;
  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic signed [16:0] diff_z;
  logic signed [16:0] num;
  logic signed [16:0] den;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;

  logic signed [XY_W-1:0] cx;
  logic signed [XY_W-1:0] cy;
  logic signed [Z_W-1:0]  cz;
  logic                   zero_arg;
  logic [STEP_W-1:0]      step_cnt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [15:0]     roll_angle;

  function automatic logic signed [15:0] round_angle(input logic signed [Z_W-1:0] zv,
                                                     input logic zero);
    logic signed [Z_W-1:0] zr;
    logic signed [Z_W-9:0] r;
    logic signed [15:0]    a;
    zr = zv + Z_W'(128);
    r  = zr[Z_W-1:8];
    if (zero) begin
      a = '0;
    end else if (r > LIM_HI) begin
      a = LIM_HI[15:0];
    end else if (r < LIM_LO) begin
      a = LIM_LO[15:0];
    end else begin
      a = r[15:0];
    end
    return a;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= SYNC_RESET;
      accel_center <= CENTER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:    sync_byte    <= cfg_data[7:0];
        CFG_ACCEL_CENTER: accel_center <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Frame position and checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
    end else if (cmd.frame_start) begin
      byte_position <= 4'd1;
      running_sum   <= rx_byte;
    end else if (cmd.data_take) begin
      byte_position <= byte_position + 4'd1;
      running_sum   <= running_sum + rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      if (cmd.data_take && byte_position == 4'(k + 1)) begin
        payload_store[k] <= rx_byte;
      end
    end
  end

  assign status.sync_hit    = (rx_byte == sync_byte);
  assign status.pos_last    = (byte_position == FRAME_LAST);
  assign status.sum_match   = (rx_byte == running_sum);
  assign status.cordic_last = (step_cnt == STEP_LAST);
  assign status.out_busy    = out_valid && out_stall;

  // CORDIC start values: centred differences scaled by 256, folded into
  // the right half plane by a quarter turn when the denominator is negative.
  assign ax     = {payload_store[4], payload_store[5]};
  assign ay     = {payload_store[6], payload_store[7]};
  assign az     = {payload_store[8], payload_store[9]};
  assign diff_x = signed'({1'b0, ax}) - signed'({1'b0, accel_center});
  assign diff_y = signed'({1'b0, ay}) - signed'({1'b0, accel_center});
  assign diff_z = signed'({1'b0, az}) - signed'({1'b0, accel_center});
  assign num    = cmd.pitch_sel ? diff_y : diff_x;
  assign den    = diff_z;
  assign x0     = {{(XY_W-25){den[16]}}, den, 8'd0};
  assign y0     = {{(XY_W-25){num[16]}}, num, 8'd0};

  assign xs = cx >>> step_cnt;
  assign ys = cy >>> step_cnt;

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      step_cnt <= '0;
      zero_arg <= (num == '0) && (den == '0);
      if (x0[XY_W-1]) begin
        if (!y0[XY_W-1]) begin
          cx <= y0;
          cy <= -x0;
          cz <= Z_W'(QUARTER_TURN);
        end else begin
          cx <= -y0;
          cy <= x0;
          cz <= -Z_W'(QUARTER_TURN);
        end
      end else begin
        cx <= x0;
        cy <= y0;
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      step_cnt <= step_cnt + STEP_W'(1);
      if (!cy[XY_W-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_step(step_cnt);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_step(step_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.roll_capture) begin
      roll_angle <= round_angle(cz, zero_arg);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stick_x        <= payload_store[0];
      stick_y        <= payload_store[1];
      button_first   <= payload_store[2];
      button_second  <= payload_store[3];
      accel_x        <= ax;
      accel_y        <= ay;
      accel_z        <= az;
      roll_centideg  <= roll_angle;
      pitch_centideg <= round_angle(cz, zero_arg);
    end
  end

endmodule

// File: hdl/sync_frame_checksum_tilt_decode_unit.sv
// Bytes are taken without a stall while the unit hunts for sync or reads a frame.
// After an accepted checksum byte that matches, the input stalls while one shared
// CORDIC runs roll and then pitch, one iteration a cycle, and for longer while the
// result side still holds the previous result.
// Synchronous reset: hunting for sync, no result pending, registers at 0xAA and 511.
// ----------------------------------------------------------------------------
// Sync frame checksum tilt decode unit
// Hunts for a sync byte, checks a sum-of-bytes frame and reports stick,
// button and accelerometer fields with roll and pitch tilt angles.
// ----------------------------------------------------------------------------
module sync_frame_checksum_tilt_decode_unit #(
  parameter int CORDIC_STEPS = sfctd_pkg::DEFAULT_CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sfctd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfctd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        stick_x,
  output logic [7:0]                        stick_y,
  output logic [7:0]                        button_first,
  output logic [7:0]                        button_second,
  output logic [15:0]                       accel_x,
  output logic [15:0]                       accel_y,
  output logic [15:0]                       accel_z,
  output logic signed [15:0]                roll_centideg,
  output logic signed [15:0]                pitch_centideg
);
  import sfctd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sfctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfctd_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .stick_x        (stick_x),
    .stick_y        (stick_y),
    .button_first   (button_first),
    .button_second  (button_second),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .roll_centideg  (roll_centideg),
    .pitch_centideg (pitch_centideg)
  );

endmodule
